### rtl/ubra_pkg.sv
// Shared types, field widths, codes and reset values of the unit bump region allocator.
package ubra_pkg;

  // Default geometry of the region
  localparam int REGION_UNITS_DEF = 4096;
  localparam int WORD_LOG2_DEF    = 6;

  // Sizes behind the line width reset value
  localparam int LINE_BYTES = 4;
  localparam int UNIT_BYTES = 16;

  // Request and result field widths
  localparam int FUNC_W = 3;
  localparam int CNT_W  = 13;
  localparam int IDX_W  = 12;
  localparam int OLD_W  = 13;
  localparam int ALN_W  = 9;
  localparam int P_W    = ALN_W + 1;

  // Configuration register widths
  localparam int CAP_W      = 13;
  localparam int BASE_W     = 12;
  localparam int LINE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE     = 2'd2;

  // Configuration reset values
  localparam logic [CAP_W-1:0]  CAP_RST  = 13'd4028;
  localparam logic [BASE_W-1:0] BASE_RST = 12'd68;
  localparam logic [LINE_W-1:0] LINE_RST = LINE_W'(LINE_BYTES * UNIT_BYTES / UNIT_BYTES);

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 3'd0,
    FN_ALIGNED = 3'd1,
    FN_LFREE   = 3'd2,
    FN_RFREE   = 3'd3,
    FN_RECLAIM = 3'd4,
    FN_GROW    = 3'd5
  } func_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic alloc_chk;
    logic set_start;
    logic free_rd;
    logic free_wr;
    logic free_fin;
    logic rf_rd;
    logic rf_wr;
    logic scan_init;
    logic scan_rd;
    logic scan_chk;
    logic rc_take;
    logic rc_rd;
    logic rc_clr;
    logic rc_fin;
    logic rc_dec;
    logic grow;
    logic done;
  } ubra_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    func_t func;
    logic  idx_in;
    logic  hit;
    logic  scan_last;
    logic  found;
    logic  x_nz;
    logic  rc_break;
    logic  rw_last;
  } ubra_stat_t;

endpackage

### rtl/ubra_ctrl.sv
// Controller state machine of the unit bump region allocator.
module ubra_ctrl
  import ubra_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_free,
  input  ubra_stat_t st,
  output logic       in_ready,
  output ubra_cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_DISP     = 16'h0002,
    S_ACHK     = 16'h0004,
    S_SETS     = 16'h0008,
    S_FREE_RD  = 16'h0010,
    S_FREE_WR  = 16'h0020,
    S_FREE_FIN = 16'h0040,
    S_RF_RD    = 16'h0080,
    S_RF_WR    = 16'h0100,
    S_SCAN_RD  = 16'h0200,
    S_SCAN_CHK = 16'h0400,
    S_RC_FIRST = 16'h0800,
    S_RC_RD    = 16'h1000,
    S_RC_CHK   = 16'h2000,
    S_RC_FIN   = 16'h4000,
    S_DONE     = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   first_r, first_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    first_nxt = first_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.func)
          FN_ALLOC, FN_ALIGNED: state_nxt = S_ACHK;
          FN_LFREE: state_nxt = st.idx_in ? S_FREE_RD : S_DONE;
          FN_RFREE: state_nxt = st.idx_in ? S_RF_RD : S_DONE;
          FN_RECLAIM: begin
            cmd.scan_init = 1'b1;
            ret_nxt       = S_RC_FIRST;
            state_nxt     = S_SCAN_RD;
          end
          FN_GROW: begin
            cmd.grow  = 1'b1;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_ACHK: begin
        cmd.alloc_chk = 1'b1;
        state_nxt     = S_SETS;
      end
      S_SETS: begin
        cmd.set_start = 1'b1;
        state_nxt     = S_DONE;
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.free_wr   = 1'b1;
        cmd.scan_init = 1'b1;
        ret_nxt       = S_FREE_FIN;
        state_nxt     = S_SCAN_RD;
      end
      S_FREE_FIN: begin
        cmd.free_fin = 1'b1;
        state_nxt    = S_DONE;
      end
      S_RF_RD: begin
        cmd.rf_rd = 1'b1;
        state_nxt = S_RF_WR;
      end
      S_RF_WR: begin
        cmd.rf_wr = 1'b1;
        state_nxt = S_DONE;
      end
      // Walk start words downward: read a word, then check it
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = (st.hit || st.scan_last) ? ret_r : S_SCAN_RD;
      end
      S_RC_FIRST: begin
        if (!st.found) begin
          state_nxt = S_ACHK;
        end else begin
          cmd.rc_take = 1'b1;
          first_nxt   = 1'b1;
          state_nxt   = S_RC_RD;
        end
      end
      S_RC_RD: begin
        cmd.rc_rd = 1'b1;
        state_nxt = S_RC_CHK;
      end
      S_RC_CHK: begin
        first_nxt = 1'b0;
        if (st.x_nz) begin
          cmd.rc_clr    = 1'b1;
          cmd.scan_init = 1'b1;
          ret_nxt       = S_RC_FIN;
          state_nxt     = S_SCAN_RD;
        end else if (first_r || st.rw_last) begin
          state_nxt = S_ACHK;
        end else begin
          cmd.rc_dec = 1'b1;
          state_nxt  = S_RC_RD;
        end
      end
      S_RC_FIN: begin
        cmd.rc_fin = 1'b1;
        if (st.rc_break || st.rw_last) begin
          state_nxt = S_ACHK;
        end else begin
          cmd.rc_dec = 1'b1;
          state_nxt  = S_RC_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

### rtl/ubra_dp.sv
// Datapath of the unit bump region allocator: bump pointer, mark memories, scan and results.
module ubra_dp
  import ubra_pkg::*;
#(
  parameter int REGION_UNITS = REGION_UNITS_DEF,
  parameter int WORD_LOG2    = WORD_LOG2_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ubra_cmd_t         cmd,
  input  logic [FUNC_W-1:0] func,
  input  logic [CNT_W-1:0]  unit_count,
  input  logic [IDX_W-1:0]  unit_index,
  input  logic [OLD_W-1:0]  old_units,
  input  logic [ALN_W-1:0]  align_units,
  input  logic [CAP_W-1:0]  capacity_units,
  input  logic [BASE_W-1:0] base_offset_units,
  input  logic [LINE_W-1:0] line_units,
  output ubra_stat_t        st,
  output logic              res_ok,
  output logic [IDX_W-1:0]  res_start,
  output logic              res_empty
);

  localparam int WB = 1 << WORD_LOG2;
  localparam int NW = REGION_UNITS >> WORD_LOG2;
  localparam int WW = (NW > 1) ? $clog2(NW) : 1;
  localparam int UW = WW + WORD_LOG2;
  localparam int PW = $clog2(REGION_UNITS + 1);
  localparam int CW = ((PW > CNT_W) ? PW : CNT_W) + 2;

  // Latched request
  func_t            fn_r;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] idx_r;
  logic [OLD_W-1:0] o_r;
  logic [P_W-1:0]   p_r;
  logic [P_W-1:0]   p_nxt;

  logic [PW-1:0] bump_r;
  logic [CW-1:0] cand_r, end_r;
  logic          fit_r;
  logic [WW-1:0] w_r, rw_r;
  logic          found_r;
  logic [UW-1:0] top_r, lsb_r;

  logic             res_ok_r, res_empty_r;
  logic [IDX_W-1:0] res_start_r;

  // Mark memories with per-word valid bits
  logic [WB-1:0] s_mem [NW];
  logic [WB-1:0] r_mem [NW];
  logic [NW-1:0] s_vld_r, r_vld_r;
  logic [WB-1:0] s_q, r_q;
  logic          s_vq, r_vq;

  logic          s_re, s_we, r_re, r_we;
  logic [WW-1:0] s_raddr, s_waddr, r_raddr, r_waddr;
  logic [WB-1:0] s_wdata, r_wdata;

  logic [CW-1:0] bump_c, cap_eff, idx_c, region_c, pm, msk;
  logic [CW-1:0] bit_a, nn, cand, cend, bw;
  logic          cfit, aligned, keep, rc_stop;
  logic [WB-1:0] s_word, r_word, cand_bit, idx_bit;
  logic [WORD_LOG2-1:0] hb, lb;
  logic [WW-1:0] scan_init_w;

  // Round the alignment up to a power of two
  always_comb begin
    p_nxt = P_W'(1);
    for (int k = P_W - 1; k >= 0; k--) begin
      if ((P_W'(1) << k) >= P_W'(align_units)) p_nxt = P_W'(1) << k;
    end
  end

  assign s_word = s_vq ? s_q : '0;
  assign r_word = r_vq ? r_q : '0;

  // Placement arithmetic
  always_comb begin
    bump_c   = CW'(bump_r);
    region_c = CW'(REGION_UNITS);
    cap_eff  = (CW'(capacity_units) > region_c) ? region_c : CW'(capacity_units);
    idx_c    = CW'(idx_r);
    aligned  = (fn_r == FN_ALIGNED);
    pm       = CW'(p_r) - CW'(1);
    msk      = ~pm;
    bit_a    = (bump_c + pm) & msk;
    if (CW'(p_r) > CW'(line_units)) begin
      bit_a = bit_a + ((CW'(base_offset_units) + pm) & msk) - CW'(base_offset_units);
    end
    nn       = (CW'(n_r) + pm) & msk;
    cand     = aligned ? bit_a : bump_c;
    cend     = cand + (aligned ? nn : CW'(n_r));
    cfit     = (cend <= cap_eff) && (cand < region_c);
    bw       = bump_c >> WORD_LOG2;
    scan_init_w = (bw > CW'(NW - 1)) ? WW'(NW - 1) : bw[WW-1:0];
    cand_bit = WB'(1) << cand_r[WORD_LOG2-1:0];
    idx_bit  = WB'(1) << idx_c[WORD_LOG2-1:0];
  end

  // Highest set bit of the start word, lowest of the remote word
  always_comb begin
    hb = '0;
    for (int k = 0; k < WB; k++) begin
      if (s_word[k]) hb = WORD_LOG2'(k);
    end
    lb = '0;
    for (int k = WB - 1; k >= 0; k--) begin
      if (r_word[k]) lb = WORD_LOG2'(k);
    end
  end

  assign keep    = found_r && (CW'(top_r) >= idx_c);
  assign rc_stop = found_r && (top_r >= lsb_r);

  // Memory port steering
  always_comb begin
    s_re    = 1'b0;
    s_raddr = w_r;
    s_we    = 1'b0;
    s_waddr = rw_r;
    s_wdata = s_word;
    r_re    = 1'b0;
    r_raddr = rw_r;
    r_we    = 1'b0;
    r_waddr = rw_r;
    r_wdata = '0;
    if (cmd.alloc_chk) begin
      s_re    = 1'b1;
      s_raddr = cand[WORD_LOG2 +: WW];
    end else if (cmd.free_rd) begin
      s_re    = 1'b1;
      s_raddr = idx_c[WORD_LOG2 +: WW];
    end else if (cmd.scan_rd) begin
      s_re    = 1'b1;
      s_raddr = w_r;
    end else if (cmd.rc_rd) begin
      s_re    = 1'b1;
      s_raddr = rw_r;
      r_re    = 1'b1;
      r_raddr = rw_r;
    end else if (cmd.rf_rd) begin
      r_re    = 1'b1;
      r_raddr = idx_c[WORD_LOG2 +: WW];
    end
    if (cmd.set_start && fit_r) begin
      s_we    = 1'b1;
      s_waddr = cand_r[WORD_LOG2 +: WW];
      s_wdata = s_word | cand_bit;
    end else if (cmd.free_wr) begin
      s_we    = 1'b1;
      s_waddr = idx_c[WORD_LOG2 +: WW];
      s_wdata = s_word & ~idx_bit;
    end else if (cmd.rc_clr) begin
      s_we    = 1'b1;
      s_waddr = rw_r;
      s_wdata = s_word & ~r_word;
      r_we    = 1'b1;
      r_waddr = rw_r;
      r_wdata = '0;
    end else if (cmd.rf_wr) begin
      r_we    = 1'b1;
      r_waddr = idx_c[WORD_LOG2 +: WW];
      r_wdata = r_word | idx_bit;
    end
  end

  // Mark memories
  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_waddr] <= s_wdata;
    if (s_re) s_q <= s_mem[s_raddr];
    if (r_we) r_mem[r_waddr] <= r_wdata;
    if (r_re) r_q <= r_mem[r_raddr];
  end

  // Valid bits stand for the cleared reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= '0;
      r_vld_r <= '0;
      s_vq    <= 1'b0;
      r_vq    <= 1'b0;
    end else begin
      if (s_we) s_vld_r[s_waddr] <= 1'b1;
      if (r_we) r_vld_r[r_waddr] <= 1'b1;
      if (s_re) s_vq <= s_vld_r[s_raddr];
      if (r_re) r_vq <= r_vld_r[r_raddr];
    end
  end

  // Bump pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_r <= '0;
    end else if (cmd.set_start && fit_r) begin
      bump_r <= PW'(end_r);
    end else if (cmd.free_fin && !keep) begin
      bump_r <= found_r ? PW'(idx_c) : '0;
    end else if (cmd.rc_fin && !rc_stop) begin
      bump_r <= found_r ? PW'(lsb_r) : '0;
    end else if (cmd.grow && (bump_c == idx_c + CW'(o_r))
                 && (idx_c + CW'(n_r) <= cap_eff)) begin
      bump_r <= PW'(idx_c + CW'(n_r));
    end
  end

  // Request, placement and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn_r  <= func_t'(func);
      n_r   <= unit_count;
      idx_r <= unit_index;
      o_r   <= old_units;
      p_r   <= p_nxt;
    end
    if (cmd.alloc_chk) begin
      cand_r <= cand;
      end_r  <= cend;
      fit_r  <= cfit;
    end
    if (cmd.scan_init) begin
      w_r     <= scan_init_w;
      found_r <= 1'b0;
    end else if (cmd.scan_chk) begin
      if (|s_word) begin
        found_r <= 1'b1;
        top_r   <= {w_r, hb};
      end else if (w_r != '0) begin
        w_r <= w_r - WW'(1);
      end
    end
    if (cmd.rc_take) begin
      rw_r <= w_r;
    end else if (cmd.rc_dec) begin
      rw_r <= rw_r - WW'(1);
    end
    if (cmd.rc_clr) lsb_r <= {rw_r, lb};
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_ok_r    <= 1'b0;
      res_start_r <= '0;
      res_empty_r <= 1'b0;
    end else if (cmd.set_start && fit_r) begin
      res_ok_r    <= 1'b1;
      res_start_r <= IDX_W'(cand_r);
    end else if (cmd.free_fin && !keep) begin
      res_empty_r <= found_r ? (idx_c == '0) : 1'b1;
    end else if (cmd.grow && (bump_c == idx_c + CW'(o_r))
                 && (idx_c + CW'(n_r) <= cap_eff)) begin
      res_ok_r    <= 1'b1;
      res_start_r <= idx_r;
    end
  end

  assign st.func      = fn_r;
  assign st.idx_in    = idx_c < region_c;
  assign st.hit       = |s_word;
  assign st.scan_last = (w_r == '0);
  assign st.found     = found_r;
  assign st.x_nz      = |r_word;
  assign st.rc_break  = rc_stop || !found_r || (lsb_r == '0);
  assign st.rw_last   = (rw_r == '0);

  assign res_ok    = res_ok_r;
  assign res_start = res_start_r;
  assign res_empty = res_empty_r;

endmodule

### rtl/unit_bump_region_allocator_core.sv
// Top level of the unit bump region allocator: configuration, result register and wiring.
//
//  Channel | Direction | Handshake           | Payload
//  in_     | slave     | in_tvalid/in_tready | in_tdata: func, unit_count, unit_index, ...
//  out_    | master    | out_tvalid/out_tready | out_tdata: ok, start_unit, region_empty
//  cfg_    | write     | cfg_we              | cfg_addr, cfg_wdata
//
// One request at a time. A local free walks start words down from the bump pointer. Reclaim
// walks start words the same way, then remote words downward, plus one such walk per
// reclaimed word. The single read port of each mark memory sets the walk rate. Reset is
// synchronous and clears the marks at once through per-word valid bits. A held result
// stalls the next one only.
module unit_bump_region_allocator_core
  import ubra_pkg::*;
#(
  parameter int REGION_UNITS = REGION_UNITS_DEF,
  parameter int WORD_LOG2    = WORD_LOG2_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // func[2:0], unit_count[15:3], unit_index[27:16], old_units[40:28], align_units[49:41]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // ok[0], start_unit[12:1], region_empty[13]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  ubra_cmd_t  cmd;
  ubra_stat_t st;

  logic [CAP_W-1:0]  cap_r;
  logic [BASE_W-1:0] base_r;
  logic [LINE_W-1:0] line_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_free;
  logic                   res_ok, res_empty;
  logic [IDX_W-1:0]       res_start;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RST;
      base_r <= BASE_RST;
      line_r <= LINE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CAPACITY: cap_r  <= cfg_wdata;
        CFG_BASE:     base_r <= cfg_wdata[BASE_W-1:0];
        CFG_LINE:     line_r <= cfg_wdata[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  ubra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .st       (st),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  ubra_dp #(
    .REGION_UNITS (REGION_UNITS),
    .WORD_LOG2    (WORD_LOG2)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .func              (in_tdata[2:0]),
    .unit_count        (in_tdata[15:3]),
    .unit_index        (in_tdata[27:16]),
    .old_units         (in_tdata[40:28]),
    .align_units       (in_tdata[49:41]),
    .capacity_units    (cap_r),
    .base_offset_units (base_r),
    .line_units        (line_r),
    .st                (st),
    .res_ok            (res_ok),
    .res_start         (res_start),
    .res_empty         (res_empty)
  );

  // Result register
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) out_tdata_r <= {2'b00, res_empty, res_start, res_ok};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while busy");

  a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |-> (!out_tvalid_r || out_tready))
    else $error("result overwrote a held result");

  a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tdata_r[0]) |-> (out_tdata_r[12:1] == '0))
    else $error("failed result carries a start unit");

endmodule
